// ===== hdl/nfd_pkg.sv =====
// ----------------------------------------------------------------------------
// nfd_pkg
// shared types and codes of the small-page nand flash device
// ----------------------------------------------------------------------------
package nfd_pkg;

	localparam int CFG_IDX_W = 3;

	localparam logic [CFG_IDX_W-1:0] CFG_VENDOR_ID   = 3'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_DEVICE_ID   = 3'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_WRITE_PROT  = 3'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_LONG_ADDR   = 3'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_STATUS_OK   = 3'd4;
	localparam logic [CFG_IDX_W-1:0] CFG_STATUS_FAIL = 3'd5;

	localparam logic [7:0] ERASED_BYTE = 8'hFF;

	localparam logic [1:0] REQ_READ  = 2'd0;
	localparam logic [1:0] REQ_WRITE = 2'd1;
	localparam logic [1:0] REQ_ADDR  = 2'd2;
	localparam logic [1:0] REQ_CMD   = 2'd3;

	localparam logic [3:0] CMD_RESET     = 4'd0;
	localparam logic [3:0] CMD_PTR_LOW   = 4'd1;
	localparam logic [3:0] CMD_PTR_HIGH  = 4'd2;
	localparam logic [3:0] CMD_PTR_SPARE = 4'd3;
	localparam logic [3:0] CMD_STATUS    = 4'd4;
	localparam logic [3:0] CMD_ERASE     = 4'd5;
	localparam logic [3:0] CMD_ERASE_OK  = 4'd6;
	localparam logic [3:0] CMD_PROGRAM   = 4'd7;
	localparam logic [3:0] CMD_COPY      = 4'd8;
	localparam logic [3:0] CMD_WRITE_OK  = 4'd9;
	localparam logic [3:0] CMD_SIGNATURE = 4'd10;

	typedef enum logic [2:0] {
		MODE_IDLE  = 3'd0,
		MODE_READ  = 3'd1,
		MODE_ERASE = 3'd2,
		MODE_WRITE = 3'd3,
		MODE_COPY  = 3'd4,
		MODE_SIG   = 3'd5
	} mode_t;

	typedef enum logic [1:0] {
		ZONE_LOW   = 2'd0,
		ZONE_HIGH  = 2'd1,
		ZONE_SPARE = 2'd2
	} zone_t;

	typedef enum logic [1:0] {
		PH_NONE  = 2'd0,
		PH_START = 2'd1,
		PH_PROG  = 2'd2,
		PH_DONE  = 2'd3
	} phase_t;

	typedef enum logic [10:0] {
		ST_CLEAR  = 11'b000_0000_0001,
		ST_IDLE   = 11'b000_0000_0010,
		ST_EXEC   = 11'b000_0000_0100,
		ST_MUL    = 11'b000_0000_1000,
		ST_RES    = 11'b000_0001_0000,
		ST_RDWAIT = 11'b000_0010_0000,
		ST_EFIND  = 11'b000_0100_0000,
		ST_EWALK  = 11'b000_1000_0000,
		ST_CMUL   = 11'b001_0000_0000,
		ST_CWALK  = 11'b010_0000_0000,
		ST_DONE   = 11'b100_0000_0000
	} state_t;

	typedef struct packed {
		logic [7:0] vendor_id;
		logic [7:0] device_id;
		logic       write_protect;
		logic       long_address;
		logic [7:0] status_ok_byte;
		logic [7:0] status_fail_byte;
	} cfg_t;

endpackage

// ===== hdl/small_page_nand_flash_device.sv =====
// ----------------------------------------------------------------------------
// small_page_nand_flash_device
// small-page nand flash device: command, address, data-write and data-read
// ----------------------------------------------------------------------------
// flow: commands, address bytes, status and signature reads pass exec and done;
//   data writes pass exec, mul, res and done, data reads also rdwait; one item in flight
// the next item is taken once the result is pushed and the sequencer is back in idle
// erase adds a search step per block ahead and a walk over the block's bytes; copy adds a setup step and a page walk
// reset sets the control state to its initial values and sweeps the array to 0xFF,
//   one byte a cycle, with no item taken meanwhile
module small_page_nand_flash_device #(
	parameter int PAGE_DATA_BYTES = 512,
	parameter int SPARE_BYTES     = 16,
	parameter int PAGES_PER_BLOCK = 32,
	parameter int BLOCK_COUNT     = 16
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          s_tvalid,
	output logic                          s_tready,
	input  logic [15:0]                   s_tdata,   // command[3:0], data_byte[11:4]
	input  logic [1:0]                    s_tuser,   // req_type[1:0]
	output logic                          m_tvalid,
	input  logic                          m_tready,
	output logic [7:0]                    m_tdata,   // read_value[7:0]
	output logic [0:0]                    m_tuser,   // fault[0]
	input  logic                          cfg_we,
	input  logic [nfd_pkg::CFG_IDX_W-1:0] cfg_idx,
	input  logic [7:0]                    cfg_wdata
);

	localparam int FB = BLOCK_COUNT * PAGES_PER_BLOCK * (PAGE_DATA_BYTES + SPARE_BYTES);
	localparam int AW = $clog2(FB);

	nfd_pkg::cfg_t cfg;
	logic          mem_we;
	logic [AW-1:0] mem_waddr;
	logic [7:0]    mem_wdata;
	logic [AW-1:0] mem_raddr;
	logic [7:0]    mem_rdata;
	logic          fault;

	nfd_cfg u_cfg (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.cfg_idx  (cfg_idx),
		.cfg_wdata(cfg_wdata),
		.cfg      (cfg)
	);

	nfd_ctrl #(
		.PAGE_DATA_BYTES(PAGE_DATA_BYTES),
		.SPARE_BYTES    (SPARE_BYTES),
		.PAGES_PER_BLOCK(PAGES_PER_BLOCK),
		.BLOCK_COUNT    (BLOCK_COUNT),
		.AW             (AW)
	) u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.req_type  (s_tuser),
		.command   (s_tdata[3:0]),
		.data_byte (s_tdata[11:4]),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.read_value(m_tdata),
		.fault     (fault),
		.mem_we    (mem_we),
		.mem_waddr (mem_waddr),
		.mem_wdata (mem_wdata),
		.mem_raddr (mem_raddr),
		.mem_rdata (mem_rdata)
	);

	nfd_mem #(
		.DEPTH(FB),
		.AW   (AW)
	) u_mem (
		.clk  (clk),
		.we   (mem_we),
		.waddr(mem_waddr),
		.wdata(mem_wdata),
		.raddr(mem_raddr),
		.rdata(mem_rdata)
	);

	assign m_tuser = fault;

endmodule

// ===== hdl/nfd_cfg.sv =====
// ----------------------------------------------------------------------------
// nfd_cfg
// configuration registers written through the plain write port
// ----------------------------------------------------------------------------
module nfd_cfg (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_we,
	input  logic [nfd_pkg::CFG_IDX_W-1:0] cfg_idx,
	input  logic [7:0]                    cfg_wdata,
	output nfd_pkg::cfg_t                 cfg
);

	nfd_pkg::cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.vendor_id        <= 8'd32;
			cfg_q.device_id        <= 8'd117;
			cfg_q.write_protect    <= 1'b0;
			cfg_q.long_address     <= 1'b0;
			cfg_q.status_ok_byte   <= 8'd192;
			cfg_q.status_fail_byte <= 8'd193;
		end else if (cfg_we) begin
			case (cfg_idx)
				nfd_pkg::CFG_VENDOR_ID:   cfg_q.vendor_id        <= cfg_wdata;
				nfd_pkg::CFG_DEVICE_ID:   cfg_q.device_id        <= cfg_wdata;
				nfd_pkg::CFG_WRITE_PROT:  cfg_q.write_protect    <= cfg_wdata[0];
				nfd_pkg::CFG_LONG_ADDR:   cfg_q.long_address     <= cfg_wdata[0];
				nfd_pkg::CFG_STATUS_OK:   cfg_q.status_ok_byte   <= cfg_wdata;
				nfd_pkg::CFG_STATUS_FAIL: cfg_q.status_fail_byte <= cfg_wdata;
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

// ===== hdl/nfd_mem.sv =====
// ----------------------------------------------------------------------------
// nfd_mem
// flash array: one write port, one read port with registered read data
// ----------------------------------------------------------------------------
module nfd_mem #(
	parameter int DEPTH = 270336,
	parameter int AW    = 19
) (
	input  logic          clk,
	input  logic          we,
	input  logic [AW-1:0] waddr,
	input  logic [7:0]    wdata,
	input  logic [AW-1:0] raddr,
	output logic [7:0]    rdata
);

	logic [7:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

// ===== hdl/nfd_ctrl.sv =====
// ----------------------------------------------------------------------------
// nfd_ctrl
// access sequencer: decodes items, keeps the device state, drives the array
// ----------------------------------------------------------------------------
module nfd_ctrl #(
	parameter int PAGE_DATA_BYTES = 512,
	parameter int SPARE_BYTES     = 16,
	parameter int PAGES_PER_BLOCK = 32,
	parameter int BLOCK_COUNT     = 16,
	parameter int AW              = 19
) (
	input  logic          clk,
	input  logic          arst_n,
	input  nfd_pkg::cfg_t cfg,
	input  logic          s_tvalid,
	output logic          s_tready,
	input  logic [1:0]    req_type,
	input  logic [3:0]    command,
	input  logic [7:0]    data_byte,
	output logic          m_tvalid,
	input  logic          m_tready,
	output logic [7:0]    read_value,
	output logic          fault,
	output logic          mem_we,
	output logic [AW-1:0] mem_waddr,
	output logic [7:0]    mem_wdata,
	output logic [AW-1:0] mem_raddr,
	input  logic [7:0]    mem_rdata
);

	localparam int PB        = PAGE_DATA_BYTES + SPARE_BYTES;
	localparam int TP        = BLOCK_COUNT * PAGES_PER_BLOCK;
	localparam int FB        = TP * PB;
	localparam int BLK_BYTES = PAGES_PER_BLOCK * PB;
	localparam int PGW       = $clog2(TP);
	localparam int OFF_A     = (PB - 1 > PAGE_DATA_BYTES / 2 + 255) ?
	                           PB - 1 : PAGE_DATA_BYTES / 2 + 255;
	localparam int OFF_MAX   = (OFF_A > PAGE_DATA_BYTES + 15) ? OFF_A : PAGE_DATA_BYTES + 15;
	localparam int PTW       = $clog2(OFF_MAX + 2);
	localparam int PRW       = 24 + $clog2(PB);
	localparam int CW        = $clog2(BLK_BYTES + 1);

	nfd_pkg::state_t state_q, state_d;
	nfd_pkg::mode_t  mode_q, mode_d;
	nfd_pkg::zone_t  zone_q, zone_d;
	nfd_pkg::phase_t phase_q, phase_d;
	logic [2:0]      seen_q, seen_d, seen_n;
	logic [31:0]     asm_q, asm_d;
	logic [23:0]     cur_q, cur_d;
	logic [PTW-1:0]  ptr_q, ptr_d;
	logic            first_q, first_d;
	logic            ovf_q, ovf_d;
	logic            stsel_q, stsel_d;
	logic            lfail_q, lfail_d;
	logic [1:0]      sig_q, sig_d;

	logic [1:0]      req_q, req_d;
	logic [3:0]      cmd_q, cmd_d;
	logic [7:0]      dat_q, dat_d;
	logic [23:0]     page_q, page_d;
	logic [23:0]     dpage_q, dpage_d;
	logic [PTW-1:0]  off_q, off_d;
	logic            wr_q, wr_d;
	logic [PRW-1:0]  prod_q, prod_d;
	logic [PRW-1:0]  tgt;
	logic [PGW-1:0]  bpage_q, bpage_d;
	logic [AW-1:0]   waddr_q, waddr_d;
	logic [AW-1:0]   raddr_q, raddr_d;
	logic [CW-1:0]   cnt_q, cnt_d;
	logic [7:0]      val_q, val_d;
	logic            flt_q, flt_d;

	logic            out_v_q;
	logic [7:0]      out_val_q;
	logic            out_flt_q;
	logic            push;
	logic            inc2, inc3;
	logic [PTW-1:0]  off_sel;
	logic [PTW-1:0]  ptr_next;

	assign inc3 = (seen_q < 3'd3) || (seen_q == 3'd3 && cfg.long_address);
	assign inc2 = (seen_q < 3'd2) || (seen_q == 3'd2 && cfg.long_address);
	assign tgt  = prod_q + PRW'(off_q);
	assign ptr_next = off_q + PTW'(1);

	always_comb begin
		case (zone_q)
			nfd_pkg::ZONE_HIGH:  off_sel = PTW'(asm_q[7:0]) + PTW'(PAGE_DATA_BYTES / 2);
			nfd_pkg::ZONE_SPARE: off_sel = PTW'(asm_q[3:0]) + PTW'(PAGE_DATA_BYTES);
			default:             off_sel = PTW'(asm_q[7:0]);
		endcase
	end

	always_comb begin
		state_d = state_q;
		mode_d  = mode_q;
		zone_d  = zone_q;
		phase_d = phase_q;
		seen_d  = seen_q;
		seen_n  = seen_q;
		asm_d   = asm_q;
		cur_d   = cur_q;
		ptr_d   = ptr_q;
		first_d = first_q;
		ovf_d   = ovf_q;
		stsel_d = stsel_q;
		lfail_d = lfail_q;
		sig_d   = sig_q;
		req_d   = req_q;
		cmd_d   = cmd_q;
		dat_d   = dat_q;
		page_d  = page_q;
		dpage_d = dpage_q;
		off_d   = off_q;
		wr_d    = wr_q;
		prod_d  = prod_q;
		bpage_d = bpage_q;
		waddr_d = waddr_q;
		raddr_d = raddr_q;
		cnt_d   = cnt_q;
		val_d   = val_q;
		flt_d   = flt_q;
		mem_we    = 1'b0;
		mem_waddr = waddr_q;
		mem_wdata = nfd_pkg::ERASED_BYTE;
		mem_raddr = tgt[AW-1:0];
		s_tready  = 1'b0;
		push      = 1'b0;
		case (state_q)
			nfd_pkg::ST_CLEAR: begin
				mem_we  = 1'b1;
				waddr_d = waddr_q + AW'(1);
				if (waddr_q == AW'(FB - 1)) begin
					waddr_d = '0;
					state_d = nfd_pkg::ST_IDLE;
				end
			end
			nfd_pkg::ST_IDLE: begin
				s_tready = 1'b1;
				if (s_tvalid) begin
					req_d   = req_type;
					cmd_d   = command;
					dat_d   = data_byte;
					state_d = nfd_pkg::ST_EXEC;
				end
			end
			nfd_pkg::ST_EXEC: begin
				val_d   = 8'd0;
				flt_d   = 1'b0;
				state_d = nfd_pkg::ST_DONE;
				page_d  = first_q ? asm_q[31:8] : cur_q;
				off_d   = first_q ? off_sel : ptr_q;
				case (req_q)
					nfd_pkg::REQ_CMD: begin
						case (cmd_q)
							nfd_pkg::CMD_RESET: begin
								mode_d  = nfd_pkg::MODE_IDLE;
								zone_d  = nfd_pkg::ZONE_LOW;
								ptr_d   = '0;
								cur_d   = '0;
								seen_d  = 3'd0;
								ovf_d   = 1'b0;
								first_d = 1'b1;
								stsel_d = 1'b0;
								lfail_d = 1'b0;
								phase_d = nfd_pkg::PH_NONE;
							end
							nfd_pkg::CMD_PTR_LOW, nfd_pkg::CMD_PTR_HIGH,
							nfd_pkg::CMD_PTR_SPARE: begin
								stsel_d = 1'b0;
								phase_d = nfd_pkg::PH_START;
								mode_d  = nfd_pkg::MODE_READ;
								if (cmd_q == nfd_pkg::CMD_PTR_LOW) begin
									zone_d = nfd_pkg::ZONE_LOW;
								end else if (cmd_q == nfd_pkg::CMD_PTR_HIGH) begin
									zone_d = nfd_pkg::ZONE_HIGH;
								end else begin
									zone_d = nfd_pkg::ZONE_SPARE;
								end
							end
							nfd_pkg::CMD_STATUS: stsel_d = 1'b1;
							nfd_pkg::CMD_ERASE: begin
								mode_d  = nfd_pkg::MODE_ERASE;
								phase_d = nfd_pkg::PH_START;
							end
							nfd_pkg::CMD_ERASE_OK: begin
								if (mode_q == nfd_pkg::MODE_ERASE && !inc2 &&
								    asm_q < 32'(TP)) begin
									bpage_d = '0;
									waddr_d = '0;
									state_d = nfd_pkg::ST_EFIND;
								end
								lfail_d = 1'b0;
								mode_d  = nfd_pkg::MODE_IDLE;
								phase_d = nfd_pkg::PH_NONE;
							end
							nfd_pkg::CMD_PROGRAM: begin
								mode_d  = nfd_pkg::MODE_WRITE;
								lfail_d = 1'b0;
								phase_d = nfd_pkg::PH_START;
							end
							nfd_pkg::CMD_COPY: begin
								if (inc3) begin
									mode_d = nfd_pkg::MODE_IDLE;
								end else begin
									mode_d  = nfd_pkg::MODE_COPY;
									cur_d   = asm_q[31:8];
									lfail_d = 1'b0;
								end
								phase_d = nfd_pkg::PH_START;
							end
							nfd_pkg::CMD_WRITE_OK: begin
								if (mode_q == nfd_pkg::MODE_WRITE) begin
									lfail_d = 1'b0;
								end else if (mode_q == nfd_pkg::MODE_COPY) begin
									lfail_d = 1'b0;
									page_d  = cur_q;
									dpage_d = asm_q[31:8];
									if (cur_q < 24'(TP) && asm_q[31:8] < 24'(TP) &&
									    cur_q != asm_q[31:8]) begin
										state_d = nfd_pkg::ST_CMUL;
									end
								end else begin
									lfail_d = 1'b1;
								end
								mode_d  = nfd_pkg::MODE_IDLE;
								zone_d  = nfd_pkg::ZONE_LOW;
								phase_d = nfd_pkg::PH_NONE;
							end
							nfd_pkg::CMD_SIGNATURE: begin
								mode_d  = nfd_pkg::MODE_SIG;
								sig_d   = 2'd0;
								phase_d = nfd_pkg::PH_START;
							end
							default: flt_d = 1'b1;
						endcase
					end
					nfd_pkg::REQ_ADDR: begin
						if (mode_q != nfd_pkg::MODE_IDLE) begin
							if (phase_q == nfd_pkg::PH_NONE || phase_q == nfd_pkg::PH_DONE) begin
								flt_d = 1'b1;
							end else begin
								if (phase_q == nfd_pkg::PH_START) begin
									ptr_d   = '0;
									seen_n  = 3'd0;
									ovf_d   = 1'b0;
									first_d = 1'b1;
									stsel_d = 1'b0;
									lfail_d = 1'b0;
									phase_d = nfd_pkg::PH_PROG;
								end
								if (seen_n == 3'd0) begin
									asm_d = {24'd0, dat_q};
								end else begin
									asm_d = asm_q | ({24'd0, dat_q} << {seen_n[1:0], 3'b000});
								end
								if (seen_n >= 3'd3) begin
									seen_d  = 3'd4;
									phase_d = nfd_pkg::PH_DONE;
								end else begin
									seen_d = seen_n + 3'd1;
								end
							end
						end
					end
					nfd_pkg::REQ_WRITE: begin
						if (cfg.write_protect) begin
							lfail_d = 1'b1;
						end else if (mode_q != nfd_pkg::MODE_WRITE) begin
							flt_d = 1'b1;
						end else if (inc3) begin
							mode_d  = nfd_pkg::MODE_IDLE;
							lfail_d = 1'b1;
						end else if (ovf_q) begin
							flt_d = 1'b1;
						end else begin
							wr_d    = 1'b1;
							state_d = nfd_pkg::ST_MUL;
						end
					end
					default: begin
						if (stsel_q) begin
							val_d = lfail_q ? cfg.status_fail_byte : cfg.status_ok_byte;
						end else if (mode_q == nfd_pkg::MODE_SIG) begin
							if (sig_q == 2'd0) begin
								val_d = cfg.vendor_id;
								sig_d = 2'd1;
							end else if (sig_q == 2'd1) begin
								val_d = cfg.device_id;
								sig_d = 2'd2;
							end
						end else if (mode_q != nfd_pkg::MODE_READ) begin
							flt_d = 1'b1;
						end else if (inc3) begin
							mode_d = nfd_pkg::MODE_IDLE;
						end else if (ovf_q) begin
							flt_d = 1'b1;
						end else begin
							wr_d    = 1'b0;
							state_d = nfd_pkg::ST_MUL;
						end
					end
				endcase
			end
			nfd_pkg::ST_MUL: begin
				prod_d  = PRW'(page_q) * PRW'(PB);
				state_d = nfd_pkg::ST_RES;
			end
			nfd_pkg::ST_RES: begin
				if (tgt >= PRW'(FB)) begin
					flt_d   = 1'b1;
					state_d = nfd_pkg::ST_DONE;
				end else begin
					cur_d   = page_q;
					first_d = 1'b0;
					ptr_d   = ptr_next;
					if (ptr_next >= PTW'(PB)) begin
						ovf_d = 1'b1;
					end
					if (wr_q) begin
						mem_we    = 1'b1;
						mem_waddr = tgt[AW-1:0];
						mem_wdata = dat_q;
						lfail_d   = 1'b0;
						state_d   = nfd_pkg::ST_DONE;
					end else begin
						state_d = nfd_pkg::ST_RDWAIT;
					end
				end
			end
			nfd_pkg::ST_RDWAIT: begin
				val_d   = mem_rdata;
				state_d = nfd_pkg::ST_DONE;
			end
			nfd_pkg::ST_EFIND: begin
				if ((PGW+1)'(bpage_q) + (PGW+1)'(PAGES_PER_BLOCK) <= (PGW+1)'(asm_q)) begin
					bpage_d = bpage_q + PGW'(PAGES_PER_BLOCK);
					waddr_d = waddr_q + AW'(BLK_BYTES);
				end else begin
					cnt_d   = '0;
					state_d = nfd_pkg::ST_EWALK;
				end
			end
			nfd_pkg::ST_EWALK: begin
				mem_we  = 1'b1;
				waddr_d = waddr_q + AW'(1);
				cnt_d   = cnt_q + CW'(1);
				if (cnt_q == CW'(BLK_BYTES - 1)) begin
					state_d = nfd_pkg::ST_DONE;
				end
			end
			nfd_pkg::ST_CMUL: begin
				raddr_d = AW'(PRW'(page_q) * PRW'(PB));
				waddr_d = AW'(PRW'(dpage_q) * PRW'(PB));
				cnt_d   = '0;
				state_d = nfd_pkg::ST_CWALK;
			end
			nfd_pkg::ST_CWALK: begin
				mem_raddr = raddr_q + AW'(cnt_q);
				if (cnt_q != '0) begin
					mem_we    = 1'b1;
					mem_waddr = waddr_q + AW'(cnt_q) - AW'(1);
					mem_wdata = mem_rdata;
				end
				cnt_d = cnt_q + CW'(1);
				if (cnt_q == CW'(PB)) begin
					state_d = nfd_pkg::ST_DONE;
				end
			end
			nfd_pkg::ST_DONE: begin
				if (!out_v_q || m_tready) begin
					push    = 1'b1;
					state_d = nfd_pkg::ST_IDLE;
				end
			end
			default: state_d = nfd_pkg::ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= nfd_pkg::ST_CLEAR;
			mode_q  <= nfd_pkg::MODE_IDLE;
			zone_q  <= nfd_pkg::ZONE_LOW;
			phase_q <= nfd_pkg::PH_NONE;
			seen_q  <= 3'd0;
			asm_q   <= '0;
			cur_q   <= '0;
			ptr_q   <= '0;
			first_q <= 1'b1;
			ovf_q   <= 1'b0;
			stsel_q <= 1'b0;
			lfail_q <= 1'b0;
			sig_q   <= 2'd0;
			waddr_q <= '0;
			out_v_q <= 1'b0;
		end else begin
			state_q <= state_d;
			mode_q  <= mode_d;
			zone_q  <= zone_d;
			phase_q <= phase_d;
			seen_q  <= seen_d;
			asm_q   <= asm_d;
			cur_q   <= cur_d;
			ptr_q   <= ptr_d;
			first_q <= first_d;
			ovf_q   <= ovf_d;
			stsel_q <= stsel_d;
			lfail_q <= lfail_d;
			sig_q   <= sig_d;
			waddr_q <= waddr_d;
			if (push) begin
				out_v_q <= 1'b1;
			end else if (m_tready) begin
				out_v_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		req_q   <= req_d;
		cmd_q   <= cmd_d;
		dat_q   <= dat_d;
		page_q  <= page_d;
		dpage_q <= dpage_d;
		off_q   <= off_d;
		wr_q    <= wr_d;
		prod_q  <= prod_d;
		bpage_q <= bpage_d;
		raddr_q <= raddr_d;
		cnt_q   <= cnt_d;
		val_q   <= val_d;
		flt_q   <= flt_d;
		if (push) begin
			out_val_q <= val_q;
			out_flt_q <= flt_q;
		end
	end

	assign m_tvalid   = out_v_q;
	assign read_value = out_val_q;
	assign fault      = out_flt_q;

endmodule

// ===== hdl/nfd_checker.sv =====
// ----------------------------------------------------------------------------
// nfd_checker
// port-level checks of the small-page nand flash device
// ----------------------------------------------------------------------------
module nfd_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        s_tvalid,
	input logic        s_tready,
	input logic        m_tvalid,
	input logic        m_tready,
	input logic [7:0]  m_tdata,
	input logic [0:0]  m_tuser
);

	// stalled result holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
		else $error("stalled result changed");

	// faulted access reads as zero
	a_fault_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser[0] |-> m_tdata == 8'd0)
		else $error("fault with nonzero read value");

	// one item at a time
	a_one_item: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> !s_tready)
		else $error("item taken while busy");

	// a fresh result leaves the input side open
	a_result_ready: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_tvalid) |-> s_tready)
		else $error("result without return to idle");

endmodule

bind small_page_nand_flash_device nfd_checker u_nfd_checker (
	.clk     (clk),
	.arst_n  (arst_n),
	.s_tvalid(s_tvalid),
	.s_tready(s_tready),
	.m_tvalid(m_tvalid),
	.m_tready(m_tready),
	.m_tdata (m_tdata),
	.m_tuser (m_tuser)
);

// ===== dv/tb_small_page_nand_flash_device.sv =====
// ----------------------------------------------------------------------------
// tb_small_page_nand_flash_device
// self-checking bench for the small-page nand flash device: drives command,
// address, write and read items with random gaps and output stalls, predicts
// every result from a behavioral copy of the device and its flash array, and
// compares each result field by field in order
// ----------------------------------------------------------------------------
module tb_small_page_nand_flash_device;

	timeunit 1ns;
	timeprecision 1ps;

	localparam int DATA_BYTES  = 512;
	localparam int SPARE       = 16;
	localparam int BLK_PAGES   = 32;
	localparam int BLOCKS      = 16;
	localparam int PAGE_BYTES  = DATA_BYTES + SPARE;
	localparam int ALL_PAGES   = BLOCKS * BLK_PAGES;
	localparam int FLASH_BYTES = ALL_PAGES * PAGE_BYTES;
	localparam int STALL_LIMIT = 2000000;
	localparam int ERASE_BUDGET = 8;
	localparam int IDX_W       = nfd_pkg::CFG_IDX_W;

	typedef struct {
		logic [7:0] value;
		logic       fault;
	} access_result_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [15:0] s_tdata = '0;
	logic [1:0]  s_tuser = '0;
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [7:0]  m_tdata;
	logic [0:0]  m_tuser;
	logic        cfg_we = 1'b0;
	logic [IDX_W-1:0] cfg_idx = '0;
	logic [7:0]  cfg_wdata = '0;

	// device image
	logic [7:0]  vendor_r, device_r, ok_byte_r, fail_byte_r;
	logic        wprot_r, long_r;
	nfd_pkg::mode_t  dev_mode;
	nfd_pkg::zone_t  dev_zone;
	nfd_pkg::phase_t dev_phase;
	int unsigned bytes_seen;
	logic [31:0] addr_acc;
	logic [31:0] page_r, ptr_r;
	logic        first_pend, overflowed, status_sel, failed_r;
	logic [1:0]  sig_step;
	logic [7:0]  flash_mem [FLASH_BYTES];

	access_result_t pending_q[$];
	int  errors = 0;
	int  idle_cycles = 0;
	int  erases_done = 0;
	int  items_sent = 0;
	int  ready_hold = 0;
	bit  calm = 0;

	small_page_nand_flash_device i_dut (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
		.cfg_we(cfg_we), .cfg_idx(cfg_idx), .cfg_wdata(cfg_wdata)
	);

	always #5 clk = ~clk;

	function automatic bit addr_short(int unsigned need);
		return bytes_seen < need || (bytes_seen == need && long_r);
	endfunction

	function automatic int locate(output int unsigned where);
		logic [31:0] pg, off;
		longint unsigned tgt;
		where = 0;
		pg = page_r;
		off = ptr_r;
		if (addr_short(3)) begin
			dev_mode = nfd_pkg::MODE_IDLE;
			return 1;
		end
		if (overflowed)
			return 2;
		if (first_pend) begin
			pg = addr_acc >> 8;
			case (dev_zone)
				nfd_pkg::ZONE_HIGH:  off = (addr_acc & 32'hFF) + DATA_BYTES / 2;
				nfd_pkg::ZONE_SPARE: off = (addr_acc & 32'hF) + DATA_BYTES;
				default:             off = addr_acc & 32'hFF;
			endcase
		end
		tgt = longint'(pg) * PAGE_BYTES + off;
		if (tgt >= FLASH_BYTES)
			return 2;
		page_r = pg;
		first_pend = 0;
		ptr_r = off + 1;
		if (ptr_r >= PAGE_BYTES)
			overflowed = 1;
		where = int'(tgt);
		return 0;
	endfunction

	function automatic void clear_device();
		dev_mode = nfd_pkg::MODE_IDLE;
		dev_zone = nfd_pkg::ZONE_LOW;
		ptr_r = 0;
		page_r = 0;
		bytes_seen = 0;
		overflowed = 0;
		first_pend = 1;
		status_sel = 0;
		failed_r = 0;
		dev_phase = nfd_pkg::PH_NONE;
	endfunction

	function automatic logic run_command(logic [3:0] cmd);
		longint unsigned blk, src, dst;
		case (cmd)
			nfd_pkg::CMD_RESET: clear_device();
			nfd_pkg::CMD_PTR_LOW, nfd_pkg::CMD_PTR_HIGH, nfd_pkg::CMD_PTR_SPARE: begin
				status_sel = 0;
				dev_phase = nfd_pkg::PH_START;
				dev_mode = nfd_pkg::MODE_READ;
				dev_zone = (cmd == nfd_pkg::CMD_PTR_LOW) ? nfd_pkg::ZONE_LOW :
					(cmd == nfd_pkg::CMD_PTR_HIGH) ? nfd_pkg::ZONE_HIGH : nfd_pkg::ZONE_SPARE;
			end
			nfd_pkg::CMD_STATUS: status_sel = 1;
			nfd_pkg::CMD_ERASE: begin
				dev_mode = nfd_pkg::MODE_ERASE;
				dev_phase = nfd_pkg::PH_START;
			end
			nfd_pkg::CMD_ERASE_OK: begin
				if (dev_mode == nfd_pkg::MODE_ERASE && !addr_short(2)) begin
					blk = addr_acc / BLK_PAGES;
					if (blk < BLOCKS) begin
						erases_done++;
						for (int i = 0; i < BLK_PAGES * PAGE_BYTES; i++)
							flash_mem[int'(blk) * BLK_PAGES * PAGE_BYTES + i] =
								nfd_pkg::ERASED_BYTE;
					end
				end
				failed_r = 0;
				dev_mode = nfd_pkg::MODE_IDLE;
				dev_phase = nfd_pkg::PH_NONE;
			end
			nfd_pkg::CMD_PROGRAM: begin
				dev_mode = nfd_pkg::MODE_WRITE;
				failed_r = 0;
				dev_phase = nfd_pkg::PH_START;
			end
			nfd_pkg::CMD_COPY: begin
				if (addr_short(3)) begin
					dev_mode = nfd_pkg::MODE_IDLE;
				end else begin
					dev_mode = nfd_pkg::MODE_COPY;
					page_r = addr_acc >> 8;
					failed_r = 0;
				end
				dev_phase = nfd_pkg::PH_START;
			end
			nfd_pkg::CMD_WRITE_OK: begin
				if (dev_mode == nfd_pkg::MODE_WRITE) begin
					failed_r = 0;
				end else if (dev_mode == nfd_pkg::MODE_COPY) begin
					src = page_r;
					dst = addr_acc >> 8;
					if (src < ALL_PAGES && dst < ALL_PAGES && src != dst)
						for (int i = 0; i < PAGE_BYTES; i++)
							flash_mem[int'(dst) * PAGE_BYTES + i] =
								flash_mem[int'(src) * PAGE_BYTES + i];
					failed_r = 0;
				end else begin
					failed_r = 1;
				end
				dev_mode = nfd_pkg::MODE_IDLE;
				dev_zone = nfd_pkg::ZONE_LOW;
				dev_phase = nfd_pkg::PH_NONE;
			end
			nfd_pkg::CMD_SIGNATURE: begin
				dev_mode = nfd_pkg::MODE_SIG;
				sig_step = 0;
				dev_phase = nfd_pkg::PH_START;
			end
			default: return 1;
		endcase
		return 0;
	endfunction

	function automatic logic latch_addr(logic [7:0] b);
		if (dev_phase == nfd_pkg::PH_NONE || dev_phase == nfd_pkg::PH_DONE)
			return 1;
		if (dev_phase == nfd_pkg::PH_START) begin
			ptr_r = 0;
			bytes_seen = 0;
			overflowed = 0;
			first_pend = 1;
			status_sel = 0;
			failed_r = 0;
			dev_phase = nfd_pkg::PH_PROG;
		end
		if (bytes_seen == 0)
			addr_acc = {24'd0, b};
		else
			addr_acc |= {24'd0, b} << (8 * (bytes_seen & 3));
		bytes_seen++;
		if (bytes_seen >= 4) begin
			bytes_seen = 4;
			dev_phase = nfd_pkg::PH_DONE;
		end
		return 0;
	endfunction

	function automatic access_result_t device_access(logic [1:0] req, logic [3:0] cmd,
			logic [7:0] d);
		access_result_t res;
		int unsigned where;
		int r;
		res.value = 8'd0;
		res.fault = 1'b0;
		case (req)
			nfd_pkg::REQ_CMD: res.fault = run_command(cmd);
			nfd_pkg::REQ_ADDR: if (dev_mode != nfd_pkg::MODE_IDLE) res.fault = latch_addr(d);
			nfd_pkg::REQ_WRITE: begin
				if (wprot_r) begin
					failed_r = 1;
				end else if (dev_mode != nfd_pkg::MODE_WRITE) begin
					res.fault = 1;
				end else begin
					r = locate(where);
					if (r == 2) begin
						res.fault = 1;
					end else if (r == 1) begin
						failed_r = 1;
					end else begin
						flash_mem[where] = d;
						failed_r = 0;
					end
				end
			end
			default: begin
				if (status_sel) begin
					res.value = failed_r ? fail_byte_r : ok_byte_r;
				end else if (dev_mode == nfd_pkg::MODE_SIG) begin
					if (sig_step == 0) begin
						res.value = vendor_r;
						sig_step = 1;
					end else if (sig_step == 1) begin
						res.value = device_r;
						sig_step = 2;
					end
				end else if (dev_mode != nfd_pkg::MODE_READ) begin
					res.fault = 1;
				end else begin
					r = locate(where);
					if (r == 2) res.fault = 1;
					else if (r == 0) res.value = flash_mem[where];
				end
			end
		endcase
		return res;
	endfunction

	// keeps erase walks few and short
	function automatic bit erase_allowed();
		longint unsigned blk;
		if (dev_mode != nfd_pkg::MODE_ERASE || addr_short(2))
			return 1;
		blk = addr_acc / BLK_PAGES;
		return blk < 64 && (blk >= BLOCKS || erases_done < ERASE_BUDGET);
	endfunction

	function automatic int pick_gap();
		int r;
		if (calm)
			return 0;
		r = $urandom_range(0, 99);
		if (r < 55) return 0;
		if (r < 90) return $urandom_range(1, 3);
		return $urandom_range(4, 40);
	endfunction

	task automatic send_item(logic [1:0] req, logic [3:0] cmd, logic [7:0] d);
		int gap;
		gap = pick_gap();
		@(negedge clk);
		if (gap > 0) begin
			s_tvalid = 1'b0;
			repeat (gap) @(negedge clk);
		end
		s_tvalid = 1'b1;
		s_tuser = req;
		s_tdata = {4'd0, d, cmd};
		do @(posedge clk); while (!s_tready);
		pending_q.push_back(device_access(req, cmd, d));
		items_sent++;
	endtask

	task automatic send_cmd(logic [3:0] cmd);
		send_item(nfd_pkg::REQ_CMD, cmd, 8'($urandom));
	endtask

	task automatic send_read();
		send_item(nfd_pkg::REQ_READ, 4'($urandom), 8'($urandom));
	endtask

	task automatic send_addr_bytes(logic [31:0] value, int n);
		for (int i = 0; i < n; i++)
			send_item(nfd_pkg::REQ_ADDR, 4'($urandom), value[8*i +: 8]);
	endtask

	task automatic drain();
		@(negedge clk);
		s_tvalid = 1'b0;
		while (pending_q.size() != 0) @(posedge clk);
		repeat (20) @(posedge clk);
	endtask

	task automatic set_config(logic [7:0] ven, logic [7:0] dev, logic wp, logic lng,
			logic [7:0] okb, logic [7:0] failb);
		logic [7:0] vals [6];
		drain();
		vals = '{ven, dev, {7'd0, wp}, {7'd0, lng}, okb, failb};
		for (int i = 0; i < 6; i++) begin
			@(negedge clk);
			cfg_we = 1'b1;
			cfg_idx = IDX_W'(i);
			cfg_wdata = vals[i];
		end
		@(negedge clk);
		cfg_we = 1'b0;
		vendor_r = ven;
		device_r = dev;
		wprot_r = wp;
		long_r = lng;
		ok_byte_r = okb;
		fail_byte_r = failb;
	endtask

	function automatic logic [31:0] page_address(logic [23:0] pg, logic [7:0] col);
		return {pg, col};
	endfunction

	function automatic logic [23:0] pick_page();
		int r;
		r = $urandom_range(0, 99);
		if (r < 90) return 24'($urandom_range(0, ALL_PAGES - 1));
		if (r < 95) return 24'($urandom_range(ALL_PAGES, 2047));
		return 24'($urandom);
	endfunction

	function automatic int addr_count();
		int r;
		r = $urandom_range(0, 99);
		if (r < 90) return long_r ? 4 : 3;
		return $urandom_range(1, 4);
	endfunction

	task automatic test_directed();
		send_cmd(nfd_pkg::CMD_SIGNATURE);
		repeat (3) send_read();
		send_cmd(nfd_pkg::CMD_STATUS);
		send_read();
		send_item(nfd_pkg::REQ_CMD, 4'd15, 8'hFF);
		send_cmd(nfd_pkg::CMD_RESET);
		send_item(nfd_pkg::REQ_ADDR, 4'd0, 8'hA5);
		send_read();
		send_item(nfd_pkg::REQ_WRITE, 4'd0, 8'h00);
		send_cmd(nfd_pkg::CMD_PROGRAM);
		send_addr_bytes(page_address(24'd511, 8'hFF), 3);
		send_item(nfd_pkg::REQ_WRITE, 4'hF, 8'h00);
		send_cmd(nfd_pkg::CMD_WRITE_OK);
		send_cmd(nfd_pkg::CMD_PTR_HIGH);
		send_addr_bytes(page_address(24'd511, 8'hFF), 3);
		send_read();
		send_cmd(nfd_pkg::CMD_PTR_SPARE);
		send_addr_bytes(page_address(24'd511, 8'h0F), 3);
		repeat (2) send_read();
		send_cmd(nfd_pkg::CMD_WRITE_OK);
	endtask

	task automatic test_erase_copy();
		send_cmd(nfd_pkg::CMD_PROGRAM);
		send_addr_bytes(page_address(24'd3, 8'd0), 3);
		for (int i = 0; i < 4; i++) send_item(nfd_pkg::REQ_WRITE, 4'd0, 8'($urandom));
		send_cmd(nfd_pkg::CMD_WRITE_OK);
		send_cmd(nfd_pkg::CMD_PTR_LOW);
		send_addr_bytes(page_address(24'd3, 8'd0), 3);
		send_cmd(nfd_pkg::CMD_COPY);
		send_addr_bytes(page_address(24'd480, 8'd0), 3);
		send_cmd(nfd_pkg::CMD_WRITE_OK);
		send_cmd(nfd_pkg::CMD_PTR_LOW);
		send_addr_bytes(page_address(24'd480, 8'd0), 3);
		repeat (4) send_read();
		send_cmd(nfd_pkg::CMD_ERASE);
		send_addr_bytes(32'd480, 2);
		send_cmd(nfd_pkg::CMD_ERASE_OK);
		send_cmd(nfd_pkg::CMD_ERASE);
		send_addr_bytes(32'd600, 2);
		send_cmd(nfd_pkg::CMD_ERASE_OK);
		send_cmd(nfd_pkg::CMD_PTR_LOW);
		send_addr_bytes(page_address(24'd480, 8'd0), 3);
		repeat (2) send_read();
	endtask

	task automatic test_random(int count);
		int stop_at, kind, n;
		logic [23:0] pg;
		logic [7:0] col;
		logic [3:0] c;
		stop_at = items_sent + count;
		while (items_sent < stop_at) begin
			calm = ($urandom_range(0, 7) == 0);
			kind = $urandom_range(0, 99);
			pg = pick_page();
			col = 8'($urandom);
			if (kind < 25) begin
				send_cmd(4'($urandom_range(nfd_pkg::CMD_PTR_LOW, nfd_pkg::CMD_PTR_SPARE)));
				send_addr_bytes(page_address(pg, col), addr_count());
				n = $urandom_range(1, 24);
				repeat (n) send_read();
			end else if (kind < 50) begin
				send_cmd(nfd_pkg::CMD_PROGRAM);
				send_addr_bytes(page_address(pg, col), addr_count());
				n = $urandom_range(1, 16);
				repeat (n) send_item(nfd_pkg::REQ_WRITE, 4'($urandom), 8'($urandom));
				if ($urandom_range(0, 9) != 0) send_cmd(nfd_pkg::CMD_WRITE_OK);
				if ($urandom_range(0, 1)) begin
					send_cmd(nfd_pkg::CMD_PTR_LOW);
					send_addr_bytes(page_address(pg, col), long_r ? 4 : 3);
					repeat (n) send_read();
				end
			end else if (kind < 54) begin
				send_cmd(nfd_pkg::CMD_ERASE);
				send_addr_bytes(32'($urandom_range(0, 2047)), long_r ? 3 : 2);
				if (erase_allowed()) send_cmd(nfd_pkg::CMD_ERASE_OK);
				else send_cmd(nfd_pkg::CMD_RESET);
			end else if (kind < 64) begin
				send_cmd(nfd_pkg::CMD_PTR_LOW);
				send_addr_bytes(page_address(pg, col), addr_count());
				send_cmd(nfd_pkg::CMD_COPY);
				send_addr_bytes(page_address(pick_page(), 8'($urandom)), addr_count());
				send_cmd(nfd_pkg::CMD_WRITE_OK);
			end else if (kind < 72) begin
				send_cmd(nfd_pkg::CMD_STATUS);
				n = $urandom_range(1, 3);
				repeat (n) send_read();
			end else if (kind < 80) begin
				send_cmd(nfd_pkg::CMD_SIGNATURE);
				n = $urandom_range(1, 4);
				repeat (n) send_read();
			end else begin
				n = $urandom_range(1, 6);
				repeat (n) begin
					c = 4'($urandom);
					if (c == nfd_pkg::CMD_ERASE_OK && !erase_allowed())
						c = nfd_pkg::CMD_STATUS;
					send_item(2'($urandom), c, 8'($urandom));
				end
			end
		end
	endtask

	// result checking and watchdog
	always @(posedge clk) begin
		access_result_t want;
		if (arst_n) begin
			if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
				idle_cycles = 0;
			else
				idle_cycles++;
			if (idle_cycles >= STALL_LIMIT) begin
				$display("small_page_nand_flash_device: mismatch");
				$finish;
			end
			if (m_tvalid && m_tready) begin
				if (pending_q.size() == 0) begin
					errors++;
					$display("%t unexpected item value %h fault %b", $realtime,
						m_tdata, m_tuser[0]);
				end else begin
					want = pending_q[0];
					pending_q.delete(0);
					if (m_tdata !== want.value) begin
						errors++;
						$display("%t read_value expected %h actual %h", $realtime,
							want.value, m_tdata);
					end
					if (m_tuser[0] !== want.fault) begin
						errors++;
						$display("%t fault expected %b actual %b", $realtime,
							want.fault, m_tuser[0]);
					end
				end
			end
		end
	end

	// output backpressure
	always @(negedge clk) begin
		int r;
		if (ready_hold > 0) begin
			ready_hold--;
		end else begin
			r = $urandom_range(0, 99);
			if (r < 60) begin
				m_tready = 1'b1;
				ready_hold = $urandom_range(0, 30);
			end else if (r < 90) begin
				m_tready = 1'b0;
				ready_hold = $urandom_range(0, 2);
			end else begin
				m_tready = 1'b0;
				ready_hold = $urandom_range(5, 40);
			end
		end
	end

	initial begin
		vendor_r = 8'd32;
		device_r = 8'd117;
		wprot_r = 1'b0;
		long_r = 1'b0;
		ok_byte_r = 8'd192;
		fail_byte_r = 8'd193;
		clear_device();
		addr_acc = 0;
		sig_step = 0;
		for (int i = 0; i < FLASH_BYTES; i++)
			flash_mem[i] = nfd_pkg::ERASED_BYTE;
		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		test_directed();
		test_erase_copy();
		test_random(400);
		set_config(8'd0, 8'd255, 1'b0, 1'b1, 8'd0, 8'd255);
		test_random(400);
		set_config(8'd255, 8'd0, 1'b1, 1'b0, 8'd255, 8'd0);
		test_random(300);
		set_config(8'($urandom), 8'($urandom), 1'b1, 1'b1, 8'($urandom), 8'($urandom));
		test_random(100);
		set_config(8'($urandom), 8'($urandom), 1'b0, 1'b0, 8'($urandom), 8'($urandom));
		test_random(400);
		drain();

		if (errors == 0)
			$display("small_page_nand_flash_device: match");
		else
			$display("small_page_nand_flash_device: mismatch");
		$finish;
	end

endmodule

// ===== small_page_nand_flash_device.f =====
hdl/nfd_pkg.sv
hdl/nfd_cfg.sv
hdl/nfd_mem.sv
hdl/nfd_ctrl.sv
hdl/small_page_nand_flash_device.sv
hdl/nfd_checker.sv
dv/tb_small_page_nand_flash_device.sv
